/* sv/tlp_pkg.sv */
// package for the telemetry line parser: field types, character codes, hex decode
package tlp_pkg;

    // character codes and parse positions
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] GEAR_MIN    = 8'd32;
    localparam logic [7:0] GEAR_RESET  = 8'd32;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
    localparam logic [3:0] POS_GEAR    = 4'd0;
    localparam logic [3:0] POS_DONE    = 4'd13;

    // pair indexes
    localparam logic [2:0] PAIR_RPM      = 3'd0;
    localparam logic [2:0] PAIR_SPEED_LO = 3'd1;
    localparam logic [2:0] PAIR_SPEED_HI = 3'd2;
    localparam logic [2:0] PAIR_MAP      = 3'd3;
    localparam logic [2:0] PAIR_ABS      = 3'd4;

    // decoded frame fields
    typedef struct packed {
        logic [7:0]  gear;
        logic [7:0]  rpm;
        logic [15:0] speed;
        logic [7:0]  emap;
        logic [7:0]  abs_lvl;
        logic [7:0]  tc_lvl;
    } t_fields;

    // hex digit decode: bit 4 set marks a non-digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                d = c - CHAR_ZERO;
                hex_value = {1'b0, d[3:0]};
            end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
                d = c - HEX_ALPHA_OFS;
                hex_value = {1'b0, d[3:0]};
            end else begin
                hex_value = 5'h10;
            end
        end
    endfunction

endpackage

/* sv/telemetry_line_parser.sv */
// telemetry line parser: per-character frame decode with registered input and result
//
// Usage: characters of received text lines enter on the input channel
// (i_character, i_line_end marks the last character of a line) under
// i_valid / o_stall. A line starting with '!' is a telemetry frame: gear
// character then six uppercase hex pairs. When the frame line ends, one
// result transfer leaves on o_valid / i_stall with all fields and the
// wrapping frame count. Other lines produce no result.
// Timing: the line's last character enters the input register at its transfer,
// then the result register takes the decoded frame and o_valid rises.
// Throughput: one character per cycle while no result stall is held, set by
// the single decode stage between the input register and the result register.
// Reset (i_rst_n low, synchronous): both stages empty, parser back at the
// start of a line, frame count zero.
// Stall: while i_stall holds a waiting result, the input register still
// takes one more character; after that o_stall rises until the result
// transfer completes.
module telemetry_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    input  logic        i_line_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_gear,
    output logic [7:0]  o_rpm_percent,
    output logic [15:0] o_speed,
    output logic [7:0]  o_engine_map,
    output logic [7:0]  o_abs_level,
    output logic [7:0]  o_tc_level,
    output logic [31:0] o_frame_count
);

    // input register
    logic        r_s1_valid;
    logic [7:0]  r_s1_char;
    logic        r_s1_end;

    // parser state
    logic        r_at_line_start, n_at_line_start;
    logic        r_in_frame, n_in_frame;
    logic        r_parse_failed, n_parse_failed;
    logic [3:0]  r_pos, n_pos;
    logic [3:0]  r_upper, n_upper;
    tlp_pkg::t_fields r_fields, n_fields;
    logic [31:0] r_frames_seen, n_frames_seen;
    logic        emit;

    // result register
    logic        r_out_valid;
    tlp_pkg::t_fields r_out_fields;
    logic [31:0] r_out_count;

    logic        s1_go;
    logic        in_xfer;

    // zero the field of pair p and every later field
    function automatic tlp_pkg::t_fields clear_from(input tlp_pkg::t_fields f,
                                                    input logic [2:0] p);
        tlp_pkg::t_fields g;
        begin
            g = f;
            if (p == tlp_pkg::PAIR_RPM)       g.rpm     = 8'd0;
            if (p <= tlp_pkg::PAIR_SPEED_HI)  g.speed   = 16'd0;
            if (p <= tlp_pkg::PAIR_MAP)       g.emap    = 8'd0;
            if (p <= tlp_pkg::PAIR_ABS)       g.abs_lvl = 8'd0;
            g.tc_lvl = 8'd0;
            clear_from = g;
        end
    endfunction

    // handshake control
    assign s1_go   = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_go;
    assign in_xfer = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
        if (in_xfer) begin
            r_s1_char <= i_character;
            r_s1_end  <= i_line_end;
        end
    end

    // per-character decode
    always_comb begin
        logic [4:0] hv;
        logic [3:0] pm1;
        logic [7:0] byte_val;
        hv              = tlp_pkg::hex_value(r_s1_char);
        pm1             = 4'd0;
        byte_val        = 8'd0;
        n_at_line_start = r_s1_end;
        n_in_frame      = r_in_frame;
        n_parse_failed  = r_parse_failed;
        n_pos           = r_pos;
        n_upper         = r_upper;
        n_fields        = r_fields;
        n_frames_seen   = r_frames_seen;
        emit            = 1'b0;

        if (r_at_line_start) begin
            // first character decides whether this is a frame line
            if (r_s1_char == tlp_pkg::CHAR_BANG) begin
                n_in_frame     = 1'b1;
                n_parse_failed = 1'b0;
                n_pos          = tlp_pkg::POS_GEAR;
                n_upper        = 4'd0;
                n_fields       = '0;
                n_frames_seen  = r_frames_seen + 32'd1;
            end else begin
                n_in_frame = 1'b0;
            end
        end else if (r_in_frame && !r_parse_failed && r_pos < tlp_pkg::POS_DONE) begin
            if (r_pos == tlp_pkg::POS_GEAR) begin
                // gear character
                if (r_s1_char < tlp_pkg::GEAR_MIN) begin
                    n_fields.gear  = 8'd0;
                    n_parse_failed = 1'b1;
                end else begin
                    n_fields.gear = r_s1_char;
                    n_pos         = 4'd1;
                end
            end else begin
                // hex digit
                pm1 = r_pos - 4'd1;
                if (hv[4]) begin
                    n_fields       = clear_from(r_fields, pm1[3:1]);
                    n_parse_failed = 1'b1;
                end else begin
                    if (!pm1[0]) begin
                        n_upper = hv[3:0];
                    end else begin
                        byte_val = {r_upper, hv[3:0]};
                        case (pm1[3:1])
                            tlp_pkg::PAIR_RPM:      n_fields.rpm         = byte_val;
                            tlp_pkg::PAIR_SPEED_LO: n_fields.speed[7:0]  = byte_val;
                            tlp_pkg::PAIR_SPEED_HI: n_fields.speed[15:8] = byte_val;
                            tlp_pkg::PAIR_MAP:      n_fields.emap        = byte_val;
                            tlp_pkg::PAIR_ABS:      n_fields.abs_lvl     = byte_val;
                            default:                n_fields.tc_lvl      = byte_val;
                        endcase
                    end
                    n_pos = r_pos + 4'd1;
                end
            end
        end

        // end of a frame line: finish missing fields and emit
        if (r_s1_end && n_in_frame) begin
            if (!n_parse_failed && n_pos < tlp_pkg::POS_DONE) begin
                if (n_pos == tlp_pkg::POS_GEAR) begin
                    n_fields.gear = 8'd0;
                end else begin
                    pm1      = n_pos - 4'd1;
                    n_fields = clear_from(n_fields, pm1[3:1]);
                end
            end
            emit       = 1'b1;
            n_in_frame = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_in_frame      <= 1'b0;
            r_parse_failed  <= 1'b0;
            r_pos           <= tlp_pkg::POS_GEAR;
            r_upper         <= 4'd0;
            // gear holds the space character, every other field zero
            r_fields        <= {tlp_pkg::GEAR_RESET, 48'd0};
            r_frames_seen   <= 32'd0;
        end else if (r_s1_valid && s1_go) begin
            r_at_line_start <= n_at_line_start;
            r_in_frame      <= n_in_frame;
            r_parse_failed  <= n_parse_failed;
            r_pos           <= n_pos;
            r_upper         <= n_upper;
            r_fields        <= n_fields;
            r_frames_seen   <= n_frames_seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= r_s1_valid && emit;
        end
        if (s1_go && r_s1_valid && emit) begin
            r_out_fields <= n_fields;
            r_out_count  <= n_frames_seen;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_gear        = r_out_fields.gear;
    assign o_rpm_percent = r_out_fields.rpm;
    assign o_speed       = r_out_fields.speed;
    assign o_engine_map  = r_out_fields.emap;
    assign o_abs_level   = r_out_fields.abs_lvl;
    assign o_tc_level    = r_out_fields.tc_lvl;
    assign o_frame_count = r_out_count;

    // a character that does not end a line never produces a result
    a_no_result_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_go && !r_s1_end) |=> !o_valid)
        else $error("result produced by a character inside a line");

    // a cleared gear means every field is cleared
    a_gear_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gear == 8'd0) |-> (o_rpm_percent == 8'd0 && o_speed == 16'd0 &&
        o_engine_map == 8'd0 && o_abs_level == 8'd0 && o_tc_level == 8'd0))
        else $error("fields left set with a cleared gear");

    // a frame start bumps the frame counter by one
    a_frame_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_go && r_at_line_start && r_s1_char == tlp_pkg::CHAR_BANG)
        |=> (r_frames_seen == $past(r_frames_seen) + 32'd1))
        else $error("frame counter did not advance at frame start");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// testbench for telemetry_line_parser: text line stimulus, frame decode predictor, result checks
module tb_top;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    // one decoded frame as it should leave the block
    typedef struct {
        tlp_pkg::t_fields fields;
        logic [31:0]      count;
    } t_frame_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_character;
    logic        i_line_end;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_gear;
    logic [7:0]  o_rpm_percent;
    logic [15:0] o_speed;
    logic [7:0]  o_engine_map;
    logic [7:0]  o_abs_level;
    logic [7:0]  o_tc_level;
    logic [31:0] o_frame_count;

    // stimulus control
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int mismatches    = 0;

    logic [7:0]    line_buf[$];
    t_frame_report pending_frames[$];

    // frame decoder state mirrored from the block
    logic             pr_line_start;
    logic             pr_in_frame;
    logic             pr_failed;
    logic [3:0]       pr_pos;
    logic [3:0]       pr_hi_nibble;
    tlp_pkg::t_fields pr_fields;
    logic [31:0]      pr_frames;

    telemetry_line_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_character   (i_character),
        .i_line_end    (i_line_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_gear        (o_gear),
        .o_rpm_percent (o_rpm_percent),
        .o_speed       (o_speed),
        .o_engine_map  (o_engine_map),
        .o_abs_level   (o_abs_level),
        .o_tc_level    (o_tc_level),
        .o_frame_count (o_frame_count)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // uppercase hex digit check, value on v
    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        hex_digit = 1'b1;
        if (c >= tlp_pkg::CHAR_ZERO && c <= tlp_pkg::CHAR_NINE) begin
            v = c[3:0];
        end else if (c >= tlp_pkg::CHAR_UPPER_A && c <= tlp_pkg::CHAR_UPPER_F) begin
            v = c[3:0] + 4'd9;
        end else begin
            hex_digit = 1'b0;
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            hex_char = tlp_pkg::CHAR_ZERO + 8'(v);
        end else begin
            hex_char = tlp_pkg::CHAR_UPPER_A + 8'(v) - 8'd10;
        end
    endfunction

    task automatic push_pair(input logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4]));
        line_buf.push_back(hex_char(b[3:0]));
    endtask

    // a failed pair wipes its own field and every later one
    task automatic zero_fields_from(input logic [2:0] pair);
        if (pair <= tlp_pkg::PAIR_RPM) pr_fields.rpm = '0;
        if (pair <= tlp_pkg::PAIR_SPEED_HI) pr_fields.speed = '0;
        if (pair <= tlp_pkg::PAIR_MAP) pr_fields.emap = '0;
        if (pair <= tlp_pkg::PAIR_ABS) pr_fields.abs_lvl = '0;
        pr_fields.tc_lvl = '0;
    endtask

    task automatic store_pair(input logic [2:0] pair, input logic [7:0] b);
        case (pair)
            tlp_pkg::PAIR_RPM: begin
                pr_fields.rpm = b;
            end
            tlp_pkg::PAIR_SPEED_LO: begin
                pr_fields.speed[7:0] = b;
            end
            tlp_pkg::PAIR_SPEED_HI: begin
                pr_fields.speed[15:8] = b;
            end
            tlp_pkg::PAIR_MAP: begin
                pr_fields.emap = b;
            end
            tlp_pkg::PAIR_ABS: begin
                pr_fields.abs_lvl = b;
            end
            default: begin
                pr_fields.tc_lvl = b;
            end
        endcase
    endtask

    // advance the frame decoder by one accepted character
    task automatic parse_character(input logic [7:0] c, input logic e);
        logic [3:0]    nib;
        logic [2:0]    pair;
        t_frame_report rep;
        if (pr_line_start) begin
            if (c == tlp_pkg::CHAR_BANG) begin
                pr_in_frame  = 1'b1;
                pr_failed    = 1'b0;
                pr_pos       = tlp_pkg::POS_GEAR;
                pr_hi_nibble = '0;
                pr_fields    = '0;
                pr_frames    = pr_frames + 32'd1;
            end else begin
                pr_in_frame = 1'b0;
            end
        end else if (pr_in_frame && !pr_failed && pr_pos < tlp_pkg::POS_DONE) begin
            if (pr_pos == tlp_pkg::POS_GEAR) begin
                if (c < tlp_pkg::GEAR_MIN) begin
                    pr_fields.gear = '0;
                    pr_failed      = 1'b1;
                end else begin
                    pr_fields.gear = c;
                    pr_pos         = pr_pos + 4'd1;
                end
            end else begin
                pair = 3'((pr_pos - 4'd1) >> 1);
                if (!hex_digit(c, nib)) begin
                    zero_fields_from(pair);
                    pr_failed = 1'b1;
                end else begin
                    // odd positions carry the upper digit of a pair
                    if (pr_pos[0]) begin
                        pr_hi_nibble = nib;
                    end else begin
                        store_pair(pair, {pr_hi_nibble, nib});
                    end
                    pr_pos = pr_pos + 4'd1;
                end
            end
        end
        pr_line_start = e;

        // frame line ends: unfinished parts count as failed
        if (e && pr_in_frame) begin
            if (!pr_failed && pr_pos < tlp_pkg::POS_DONE) begin
                if (pr_pos == tlp_pkg::POS_GEAR) begin
                    pr_fields.gear = '0;
                end else begin
                    zero_fields_from(3'((pr_pos - 4'd1) >> 1));
                end
            end
            rep.fields = pr_fields;
            rep.count  = pr_frames;
            pending_frames.push_back(rep);
            pr_in_frame = 1'b0;
        end
    endtask

    // one input transfer; returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c, input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= c;
        i_line_end  <= e;
        do @(posedge i_clk); while (o_stall);
        parse_character(c, e);
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int k = 0; k < line_buf.size(); k++) begin
            send_char(line_buf[k], k == line_buf.size() - 1);
        end
    endtask

    task automatic wait_for_results();
        while (pending_frames.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed frames, some damaged, plus command lines and noise
    task automatic build_random_line();
        int         kind;
        int         cut;
        logic [7:0] junk;
        logic [3:0] dv;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind < 70) begin
            line_buf.push_back(tlp_pkg::CHAR_BANG);
            line_buf.push_back(8'($urandom_range(255, 32)));
            repeat (6) push_pair(8'($urandom_range(255)));
            repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(255)));
            if (kind >= 50) begin
                case ($urandom_range(2))
                    0: begin
                        // line ends early
                        cut = $urandom_range(13, 1);
                        while (line_buf.size() > cut) void'(line_buf.pop_back());
                    end
                    1: begin
                        // one digit is not uppercase hex
                        do junk = 8'($urandom_range(255)); while (hex_digit(junk, dv));
                        line_buf[$urandom_range(13, 2)] = junk;
                    end
                    default: begin
                        // control character as gear
                        line_buf[1] = 8'($urandom_range(31));
                    end
                endcase
            end
        end else if (kind < 85) begin
            line_buf.push_back(8'h41);
            line_buf.push_back(8'h54);
            repeat ($urandom_range(8)) line_buf.push_back(8'($urandom_range(126, 32)));
        end else begin
            repeat ($urandom_range(6, 1)) line_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    // extremes and special cases, one line each
    task automatic test_directed_lines();
        // frame with nothing after the marker
        line_buf = {tlp_pkg::CHAR_BANG};
        send_line();
        // gear below the printable range
        line_buf = {tlp_pkg::CHAR_BANG, 8'h1F};
        send_line();
        // full frame, gear 255, rpm 0, speed at maximum
        line_buf = {tlp_pkg::CHAR_BANG, 8'hFF};
        push_pair(8'h00);
        push_pair(8'hFF);
        push_pair(8'hFF);
        push_pair(8'h0F);
        push_pair(8'hA9);
        push_pair(8'hF0);
        send_line();
        // command line, no result
        line_buf = {8'h41, 8'h54};
        send_line();
        // lowest gear, then a lowercase digit breaks the first pair
        line_buf = {tlp_pkg::CHAR_BANG, tlp_pkg::GEAR_MIN, tlp_pkg::CHAR_ZERO + 8'd1, 8'h61};
        send_line();
        // single null character line
        line_buf = {8'h00};
        send_line();
    endtask

    task automatic test_random_lines(input int frame_target);
        int frame_items;
        frame_items = 0;
        while (frame_items < frame_target) begin
            build_random_line();
            if (line_buf[0] == tlp_pkg::CHAR_BANG) frame_items += line_buf.size();
            send_line();
        end
    endtask

    // receiver holds off while short frames keep coming
    task automatic test_output_backpressure();
        int saved_pct;
        saved_pct = send_idle_pct;
        i_valid <= 1'b0;
        @(posedge i_clk);
        hold_req = HOLD_CYCLES;
        @(negedge i_clk);
        send_idle_pct = 0;
        repeat (40) begin
            line_buf = {tlp_pkg::CHAR_BANG};
            send_line();
        end
        send_idle_pct = saved_pct;
    endtask

    // sender goes quiet until the block has delivered everything
    task automatic test_drain_pause();
        i_valid <= 1'b0;
        wait_for_results();
        @(negedge i_clk);
        repeat (3) begin
            build_random_line();
            send_line();
        end
    endtask

    // receiver side: random stall, or a counted hold when requested
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // compare each result transfer with the oldest predicted frame
    always @(posedge i_clk) begin : result_check
        t_frame_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_frames.size() == 0) begin
                $error("result transfer with no frame pending, frame_count %0h", o_frame_count);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                check_field("gear", 32'(want.fields.gear), 32'(o_gear));
                check_field("rpm_percent", 32'(want.fields.rpm), 32'(o_rpm_percent));
                check_field("speed", 32'(want.fields.speed), 32'(o_speed));
                check_field("engine_map", 32'(want.fields.emap), 32'(o_engine_map));
                check_field("abs_level", 32'(want.fields.abs_lvl), 32'(o_abs_level));
                check_field("tc_level", 32'(want.fields.tc_lvl), 32'(o_tc_level));
                check_field("frame_count", want.count, o_frame_count);
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_character   = 8'd0;
        i_line_end    = 1'b0;
        pr_line_start = 1'b1;
        pr_in_frame   = 1'b0;
        pr_failed     = 1'b0;
        pr_pos        = tlp_pkg::POS_GEAR;
        pr_hi_nibble  = '0;
        pr_fields     = '0;
        pr_fields.gear = tlp_pkg::GEAR_RESET;
        pr_frames     = '0;
        send_idle_pct = 20;
        recv_idle_pct = 69;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lines();
        test_random_lines(190);
        test_output_backpressure();

        send_idle_pct = 69;
        recv_idle_pct = 20;
        test_random_lines(190);
        test_drain_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lines(190);

        i_valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run time limit
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
sv/tlp_pkg.sv
sv/telemetry_line_parser.sv
tb/tb_top.sv
